@@ src/mavg_pkg.sv @@
package mavg_pkg;

  // Deepest ring that the filter supports; the effective order is clamped to it.
  localparam int MAX_ORDER = 64;

  localparam int SAMPLE_W   = 16;
  localparam int INIT_W     = 16;
  localparam int ORDER_W    = 7;
  localparam int SHARE_W    = 24;
  localparam int SUM_W      = 25;
  localparam int AVG_W      = 24;
  localparam int FRAC_SHIFT = 8;
  localparam int POS_W      = $clog2(MAX_ORDER);
  localparam int DIV_STEPS  = SHARE_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE = CFG_IDX_W'(1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [INIT_W-1:0]   init_t;
  typedef logic        [ORDER_W-1:0]  order_t;
  typedef logic signed [SHARE_W-1:0]  share_t;
  typedef logic        [SHARE_W-1:0]  mag_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [AVG_W-1:0]    average_t;

  localparam average_t AVG_MAX = {1'b0, {(AVG_W-1){1'b1}}};
  localparam average_t AVG_MIN = {1'b1, {(AVG_W-1){1'b0}}};
  localparam sum_t     SUM_HI  = sum_t'(AVG_MAX);
  localparam sum_t     SUM_LO  = sum_t'(AVG_MIN);

  // Widen a value with 8 fraction bits to 16 fraction bits.
  function automatic share_t scale(input sample_t x);
    return {x, {FRAC_SHIFT{1'b0}}};
  endfunction

  function automatic mag_t magnitude(input share_t x);
    share_t neg;
    neg = -x;
    return x[SHARE_W-1] ? mag_t'(neg) : mag_t'(x);
  endfunction

  // Order zero behaves as one; orders past the ring depth use the full ring.
  function automatic order_t effective_order(input order_t n);
    order_t r;
    r = n;
    if (n == '0) begin
      r = ORDER_W'(1);
    end else if (int'(n) > MAX_ORDER) begin
      r = ORDER_W'(MAX_ORDER);
    end
    return r;
  endfunction

  function automatic average_t saturate(input sum_t x);
    average_t r;
    if (x > SUM_HI) begin
      r = AVG_MAX;
    end else if (x < SUM_LO) begin
      r = AVG_MIN;
    end else begin
      r = x[AVG_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/mavg_sample_if.sv @@
interface mavg_sample_if;
  logic              valid;
  logic              ready;
  mavg_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ src/mavg_avg_if.sv @@
interface mavg_avg_if;
  logic               valid;
  logic               ready;
  mavg_pkg::average_t average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

@@ src/mavg_cfg_if.sv @@
interface mavg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mavg_pkg::CFG_IDX_W-1:0]      index;
  logic [mavg_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/mavg_ram.sv @@
module mavg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/moving_average_filter.sv @@
// Boxcar moving-average filter over a ring of per-tap shares.
//
// Channels: "samples" carries one signed sample (8 fraction bits) per beat,
// "averages" returns one signed running average (16 fraction bits) per
// sample, and "cfg" writes the order (index 0) or the starting value
// (index 1). Writes to other indexes are taken and ignored.
//
// Each sample is divided by the order in a restoring divider that produces
// one quotient bit per cycle. A sample beat is accepted in the idle state;
// the ring is read, the divider runs, and the ring update then puts the
// result on "averages". The next sample beat can be taken only once the
// block is back in the idle state after the update, so a sample is not
// taken before the last one is through.
//
// The output is held in a register. A stalled receiver lets the next sample
// be taken and divided; only the ring update waits for the held result.
//
// Reset sets order 1 and starting value 0. A configuration write reloads the
// filter (every ring entry init_value/effective order, sum init_value,
// position zero); no sample beat is taken during the reload or alongside a cfg beat.
module moving_average_filter (
  input  logic     clk,
  input  logic     rst,
  mavg_cfg_if.sink       cfg,
  mavg_sample_if.sink    samples,
  mavg_avg_if.source     averages
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_READ     = 6'b000010,
    ST_DIV      = 6'b000100,
    ST_WRITE    = 6'b001000,
    ST_RELOAD   = 6'b010000,
    ST_INIT_DIV = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration and the derived starting share.
  mavg_pkg::order_t order;
  mavg_pkg::init_t  init_value;
  mavg_pkg::share_t init_share;

  // Filter state. The ring itself lives in the RAM; a ring entry whose valid
  // bit is clear has not been written since the last reload and reads as the
  // starting share.
  mavg_pkg::sum_t                    running_sum;
  logic [mavg_pkg::POS_W-1:0]        ring_position;
  logic [mavg_pkg::MAX_ORDER-1:0]    entry_valid;

  // Divider: div_q shifts the dividend magnitude out at the top and the
  // quotient bits in at the bottom.
  mavg_pkg::mag_t                    div_q;
  mavg_pkg::order_t                  div_rem;
  logic [mavg_pkg::DIV_CNT_W-1:0]    div_count;
  logic                              div_neg;

  mavg_pkg::share_t old_share;
  mavg_pkg::average_t average_reg;
  logic               out_valid;

  logic                           cfg_hit;
  logic                           in_accept;
  logic                           out_free;
  mavg_pkg::order_t               n_eff;
  logic [mavg_pkg::POS_W-1:0]     pos_eff;
  logic [mavg_pkg::POS_W:0]       pos_inc;
  logic [mavg_pkg::POS_W-1:0]     pos_wrap;
  logic [mavg_pkg::ORDER_W:0]     trial;
  logic [mavg_pkg::ORDER_W:0]     diff;
  logic                           fits;
  mavg_pkg::order_t               rem_step;
  mavg_pkg::mag_t                 q_step;
  logic                           div_last;
  mavg_pkg::share_t               new_share;
  logic signed [mavg_pkg::SUM_W:0] sum_wide;
  mavg_pkg::sum_t                 sum_next;
  logic [mavg_pkg::SHARE_W-1:0]   ram_rd;
  logic                           ram_we;

  assign cfg.ready      = 1'b1;
  assign cfg_hit        = cfg.valid && cfg.ready &&
                          (cfg.index == mavg_pkg::REG_ORDER ||
                           cfg.index == mavg_pkg::REG_INIT_VALUE);
  // A register write restarts the filter, so a sample beat never shares its
  // edge with one.
  assign samples.ready  = (state == ST_IDLE) && !cfg.valid;
  assign in_accept      = samples.valid && samples.ready;
  assign averages.valid   = out_valid;
  assign averages.average = average_reg;
  assign out_free       = !out_valid || averages.ready;

  // Ring addressing: the position wraps at the effective order.
  assign n_eff    = mavg_pkg::effective_order(order);
  assign pos_eff  = (int'(ring_position) >= int'(n_eff)) ? '0 : ring_position;
  assign pos_inc  = (mavg_pkg::POS_W+1)'(pos_eff) + (mavg_pkg::POS_W+1)'(1);
  assign pos_wrap = (int'(pos_inc) >= int'(n_eff)) ? '0 : pos_inc[mavg_pkg::POS_W-1:0];

  // One restoring-division step per cycle.
  assign trial    = {div_rem, div_q[mavg_pkg::SHARE_W-1]};
  assign fits     = trial >= {1'b0, n_eff};
  assign diff     = trial - {1'b0, n_eff};
  assign rem_step = fits ? diff[mavg_pkg::ORDER_W-1:0] : trial[mavg_pkg::ORDER_W-1:0];
  assign q_step   = {div_q[mavg_pkg::SHARE_W-2:0], fits};
  assign div_last = (div_count == mavg_pkg::DIV_CNT_W'(mavg_pkg::DIV_STEPS - 1));

  // The quotient magnitude gets the dividend's sign back, so the share is
  // truncated toward zero.
  assign new_share = div_neg ? -$signed(div_q) : $signed(div_q);

  // The sum drops the share being replaced and gains the new one.
  assign sum_wide = (mavg_pkg::SUM_W+1)'(running_sum) - (mavg_pkg::SUM_W+1)'(old_share)
                    + (mavg_pkg::SUM_W+1)'(new_share);
  assign sum_next = sum_wide[mavg_pkg::SUM_W-1:0];

  assign ram_we = (state == ST_WRITE) && out_free;

  mavg_ram #(
    .WIDTH (mavg_pkg::SHARE_W),
    .DEPTH (mavg_pkg::MAX_ORDER)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_eff),
    .wdata (new_share),
    .re    (in_accept),
    .raddr (pos_eff),
    .rdata (ram_rd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RELOAD: begin
        state_next = ST_INIT_DIV;
      end
      ST_INIT_DIV: begin
        if (div_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // A register write always restarts the reload.
    if (cfg_hit) begin
      state_next = ST_RELOAD;
    end
  end

  // Control state and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      order         <= mavg_pkg::ORDER_W'(1);
      init_value    <= '0;
      init_share    <= '0;
      running_sum   <= '0;
      ring_position <= '0;
      entry_valid   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      // A new result is offered as soon as the ring is updated, unless a register
      // write comes with the update; otherwise the held one leaves when the receiver takes it.
      if (ram_we && !cfg_hit) begin
        out_valid <= 1'b1;
      end else if (averages.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_hit) begin
        if (cfg.index == mavg_pkg::REG_ORDER) begin
          order <= cfg.data[mavg_pkg::ORDER_W-1:0];
        end else begin
          init_value <= cfg.data[mavg_pkg::INIT_W-1:0];
        end
        entry_valid   <= '0;
        ring_position <= '0;
      end else if (state == ST_RELOAD) begin
        running_sum <= mavg_pkg::sum_t'(mavg_pkg::scale(init_value));
      end else if (state == ST_INIT_DIV && div_last) begin
        // The last quotient bit is only in q_step this cycle.
        init_share <= div_neg ? -$signed(q_step) : $signed(q_step);
      end else if (ram_we) begin
        running_sum          <= sum_next;
        ring_position        <= pos_wrap;
        entry_valid[pos_eff] <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      div_q     <= mavg_pkg::magnitude(mavg_pkg::scale(samples.sample));
      div_neg   <= samples.sample[mavg_pkg::SAMPLE_W-1];
      div_rem   <= '0;
      div_count <= '0;
    end else if (state == ST_RELOAD) begin
      div_q     <= mavg_pkg::magnitude(mavg_pkg::scale(init_value));
      div_neg   <= init_value[mavg_pkg::INIT_W-1];
      div_rem   <= '0;
      div_count <= '0;
    end else if ((state == ST_DIV || state == ST_INIT_DIV) && !div_last) begin
      div_q     <= q_step;
      div_rem   <= rem_step;
      div_count <= div_count + mavg_pkg::DIV_CNT_W'(1);
    end else if ((state == ST_DIV || state == ST_INIT_DIV) && div_last) begin
      div_q   <= q_step;
      div_rem <= rem_step;
    end

    if (state == ST_READ) begin
      old_share <= entry_valid[pos_eff] ? $signed(ram_rd) : init_share;
    end

    if (ram_we) begin
      average_reg <= mavg_pkg::saturate(sum_next);
    end
  end

endmodule

@@ test/tb_moving_average_filter.sv @@
module tb_moving_average_filter;

  // The run ends with a failure if it has not finished after this many clocks.
  localparam int CYCLE_LIMIT = 400000;

  // Register indexes past the two defined ones are taken by the block and
  // must have no effect at all.
  localparam logic [mavg_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = mavg_pkg::CFG_IDX_W'(2);
  localparam logic [mavg_pkg::CFG_IDX_W-1:0] REG_LAST_UNUSED  = {mavg_pkg::CFG_IDX_W{1'b1}};

  localparam mavg_pkg::sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam mavg_pkg::sample_t SAMPLE_MIN = 16'sh8000;

  localparam int RANDOM_PHASES    = 15;
  localparam int ITEMS_PER_PHASE  = 100;
  localparam int MAX_PAUSE        = 5;
  localparam int REPORTED_ERRORS  = 10;
  localparam int SETTLE_CYCLES    = 40;

  // Boxcar predictor. It keeps its own copy of the ring of shares, the
  // running sum and the ring position, and queues one expected average per
  // accepted sample beat.
  class filter_scoreboard;
    mavg_pkg::order_t   order_reg;
    mavg_pkg::init_t    init_reg;
    mavg_pkg::share_t   shares[mavg_pkg::MAX_ORDER];
    int                 sum;
    int                 slot;
    mavg_pkg::average_t expected[$];
    int                 errors;

    function new();
      order_reg = mavg_pkg::ORDER_W'(1);
      init_reg  = '0;
      errors    = 0;
      refill();
    endfunction

    // Order zero averages a single tap; orders past the ring use all of it.
    function int taps();
      int n;
      n = int'(order_reg);
      if (n < 1) n = 1;
      if (n > mavg_pkg::MAX_ORDER) n = mavg_pkg::MAX_ORDER;
      return n;
    endfunction

    // Every register write restarts the filter from the starting value.
    function void refill();
      int scaled;
      scaled = int'(init_reg) * (1 << mavg_pkg::FRAC_SHIFT);
      foreach (shares[i]) shares[i] = mavg_pkg::share_t'(scaled / taps());
      sum  = scaled;
      slot = 0;
    endfunction

    function void write_reg(input logic [mavg_pkg::CFG_IDX_W-1:0] idx,
                            input logic [mavg_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        mavg_pkg::REG_ORDER: begin
          order_reg = value[mavg_pkg::ORDER_W-1:0];
          refill();
        end
        mavg_pkg::REG_INIT_VALUE: begin
          init_reg = mavg_pkg::init_t'(value);
          refill();
        end
        default: ;
      endcase
    endfunction

    function void note_sample(input mavg_pkg::sample_t x);
      int n;
      int share;
      n = taps();
      // SystemVerilog integer division truncates toward zero, as required.
      share = (int'(x) * (1 << mavg_pkg::FRAC_SHIFT)) / n;
      if (slot >= n) slot = 0;
      sum = sum - int'(shares[slot]) + share;
      shares[slot] = mavg_pkg::share_t'(share);
      slot = (slot + 1 >= n) ? 0 : slot + 1;
      // The sum is kept exactly; only the reported average saturates.
      if (sum > int'(mavg_pkg::AVG_MAX)) begin
        expected.push_back(mavg_pkg::AVG_MAX);
      end else if (sum < int'(mavg_pkg::AVG_MIN)) begin
        expected.push_back(mavg_pkg::AVG_MIN);
      end else begin
        expected.push_back(mavg_pkg::average_t'(sum));
      end
    endfunction

    function void check_average(input mavg_pkg::average_t got);
      mavg_pkg::average_t want;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= REPORTED_ERRORS)
          $display("average beat %0d arrived with no sample outstanding", got);
      end else begin
        want = expected.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= REPORTED_ERRORS)
            $display("average mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  // When set, neither side inserts idle cycles, so beats go back to back.
  bit steady = 1'b0;

  filter_scoreboard sb;

  mavg_cfg_if    cfg_ch ();
  mavg_sample_if samples_ch ();
  mavg_avg_if    avg_ch ();

  moving_average_filter DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .samples  (samples_ch),
    .averages (avg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // All three channels are observed at the rising edge. Register writes and
  // sample beats feed the predictor, and every average beat is compared with
  // the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (samples_ch.valid && samples_ch.ready) sb.note_sample(samples_ch.sample);
      if (avg_ch.valid && avg_ch.ready) sb.check_average(avg_ch.average);
    end
  end

  function automatic int pause_len();
    return steady ? 0 : $urandom_range(0, MAX_PAUSE);
  endfunction

  // Every task below is entered and left at a falling edge, which is where
  // the block's inputs change. A valid that is already high is not assigned
  // again, so it never sees two assignments in one time step.
  task automatic send_sample(input mavg_pkg::sample_t x);
    int gap;
    gap = pause_len();
    if (gap != 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (!samples_ch.valid) samples_ch.valid <= 1'b1;
    samples_ch.sample <= x;
    do @(posedge clk); while (!samples_ch.ready);
    @(negedge clk);
  endtask

  // Hold the sample channel idle until every expected average has come back.
  // The block is then idle and may take register writes.
  task automatic wait_for_averages();
    samples_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_beat(input logic [mavg_pkg::CFG_IDX_W-1:0] idx,
                          input logic [mavg_pkg::CFG_DATA_W-1:0] value);
    if (!cfg_ch.valid) cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // The order word carries the full data width; only its low bits count.
  task automatic load_settings(input bit set_order,
                               input logic [mavg_pkg::CFG_DATA_W-1:0] order_word,
                               input bit set_init, input mavg_pkg::init_t init_word);
    if (set_order) cfg_beat(mavg_pkg::REG_ORDER, order_word);
    if (set_init) cfg_beat(mavg_pkg::REG_INIT_VALUE, mavg_pkg::CFG_DATA_W'(init_word));
    cfg_ch.valid <= 1'b0;
  endtask

  // A write to an undefined index must leave the ring, sum and position as
  // they are, so it is issued while the filter holds history.
  task automatic write_unmapped();
    cfg_beat(mavg_pkg::CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
             mavg_pkg::CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // The receiver stalls a random number of cycles once a result is on offer,
  // or takes it at once when it draws no stall.
  initial begin : receiver
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = pause_len();
      if (stall != 0) begin
        avg_ch.ready <= 1'b0;
        do @(posedge clk); while (!avg_ch.valid);
        repeat (stall) @(negedge clk);
      end
      avg_ch.ready <= 1'b1;
      do @(posedge clk); while (!(avg_ch.valid && avg_ch.ready));
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_moving_average_filter: FAIL");
    $finish;
  end

  initial begin : stimulus
    int                              phase;
    int                              k;
    int                              pick;
    mavg_pkg::order_t                ord;
    logic [mavg_pkg::CFG_DATA_W-1:0] order_word;
    mavg_pkg::init_t                 init_word;
    mavg_pkg::sample_t               x;

    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    samples_ch.valid  = 1'b0;
    samples_ch.sample = '0;
    avg_ch.ready      = 1'b0;
    sb = new();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Out of reset the filter passes samples straight through: order one,
    // starting value zero. Both sample extremes and the values around zero.
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(mavg_pkg::sample_t'(0));
    send_sample(mavg_pkg::sample_t'(1));
    send_sample(mavg_pkg::sample_t'(-1));

    // Order seven from a starting value of -5 leaves a truncation residue of
    // -6 in the sum. Filling the ring with the most negative sample then
    // pushes the exact sum below the 24-bit range, so the average saturates.
    wait_for_averages();
    load_settings(1'b1, mavg_pkg::CFG_DATA_W'(7), 1'b1, mavg_pkg::init_t'(-5));
    repeat (8) send_sample(SAMPLE_MIN);

    // An unmapped register write in the middle of the history changes nothing.
    wait_for_averages();
    write_unmapped();
    send_sample(mavg_pkg::sample_t'($urandom));
    send_sample(mavg_pkg::sample_t'($urandom));

    // An order of 127 (with the unused upper data bits set) uses the full
    // ring, starting from the largest value.
    wait_for_averages();
    load_settings(1'b1, 16'hFFFF, 1'b1, mavg_pkg::init_t'(32767));
    repeat (3) send_sample(SAMPLE_MAX);

    // Order zero behaves as order one.
    wait_for_averages();
    load_settings(1'b1, 16'h0000, 1'b0, '0);
    send_sample(mavg_pkg::sample_t'(12345));
    send_sample(SAMPLE_MIN);

    // Just past the ring depth, from the most negative starting value.
    wait_for_averages();
    load_settings(1'b1, mavg_pkg::CFG_DATA_W'(65), 1'b1, mavg_pkg::init_t'(-32768));
    repeat (3) send_sample(mavg_pkg::sample_t'($urandom));

    // Random phases, each opened with a fresh setting. Every fourth phase runs
    // with no idle cycles on either side. Now and then the sender waits for
    // all results to return, sometimes followed by an unmapped write.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_averages();
      steady = (phase % 4 == 3);

      case ($urandom_range(0, 5))
        0:       ord = mavg_pkg::ORDER_W'(0);
        1:       ord = mavg_pkg::ORDER_W'(1);
        2:       ord = mavg_pkg::ORDER_W'(mavg_pkg::MAX_ORDER);
        3:       ord = mavg_pkg::ORDER_W'($urandom_range(mavg_pkg::MAX_ORDER + 1,
                                                         (1 << mavg_pkg::ORDER_W) - 1));
        default: ord = mavg_pkg::ORDER_W'($urandom_range(2, mavg_pkg::MAX_ORDER - 1));
      endcase
      order_word = {(mavg_pkg::CFG_DATA_W - mavg_pkg::ORDER_W)'($urandom), ord};

      case ($urandom_range(0, 4))
        0:       init_word = mavg_pkg::init_t'(32767);
        1:       init_word = mavg_pkg::init_t'(-32768);
        2:       init_word = '0;
        default: init_word = mavg_pkg::init_t'($urandom);
      endcase

      // Write the order, the starting value, or both.
      pick = $urandom_range(0, 2);
      load_settings(pick != 1, order_word, pick != 0, init_word);

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 49) == 0) begin
          wait_for_averages();
          if ($urandom_range(0, 1) == 1) write_unmapped();
        end
        case ($urandom_range(0, 9))
          0:       x = SAMPLE_MAX;
          1:       x = SAMPLE_MIN;
          2:       x = mavg_pkg::sample_t'($urandom_range(0, 63) - 32);
          3:       x = mavg_pkg::sample_t'($urandom_range(30000, 32767));
          4:       x = mavg_pkg::sample_t'(-$urandom_range(30000, 32768));
          default: x = mavg_pkg::sample_t'($urandom);
        endcase
        send_sample(x);
      end
    end

    wait_for_averages();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_moving_average_filter: PASS");
    end else begin
      $display("tb_moving_average_filter: FAIL");
    end
    $finish;
  end

endmodule
